// ===== design/idea_pkg.sv =====
// Shared types, constants and arithmetic for the IDEA encryption pipeline.
// Used by every design module; depends on nothing else.
`default_nettype none

package idea_pkg;

  localparam int unsigned ROUNDS    = 8;
  localparam int unsigned KEY_ROT   = 25;
  localparam int unsigned IDX_WIDTH = 2;

  localparam logic [IDX_WIDTH-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_KEY_LOW  = 2'd1;

  typedef struct packed {
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
  } block_t;

  typedef logic [5:0][15:0] sk6_t;
  typedef logic [3:0][15:0] sk4_t;

  // Multiply modulo 65537, a zero word standing for 65536.
  function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] res;
    p  = {16'd0, a} * {16'd0, b};
    lo = p[15:0];
    hi = p[31:16];
    if (a == 16'd0) begin
      res = 16'd1 - b;
    end else if (b == 16'd0) begin
      res = 16'd1 - a;
    end else begin
      res = lo - hi + {15'd0, (lo < hi)};
    end
    return res;
  endfunction

  // Subkey n: word (n mod 8) of the key rotated left by 25 * (n / 8).
  // Called with constant n only, so it reduces to wiring.
  function automatic logic [15:0] subkey(input logic [127:0] key, input int unsigned n);
    logic [255:0] dbl;
    int unsigned  rot;
    int unsigned  pos;
    dbl = {key, key};
    rot = ((n >> 3) * KEY_ROT) & 32'd127;
    pos = 32'd255 - rot - 32'd16 * (n & 32'd7);
    return dbl[pos -: 16];
  endfunction

endpackage

`default_nettype wire

// ===== design/idea_round.sv =====
// One full IDEA round as three register stages with their own handshake.
// Depends on idea_pkg for the block type and modular multiply.
`default_nettype none

module idea_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire idea_pkg::block_t up_blk,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output idea_pkg::block_t     dn_blk,
  input  wire idea_pkg::sk6_t  subkeys
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  idea_pkg::block_t s1, s1_next;
  idea_pkg::block_t s2;
  logic [15:0]      s2_t0, s2_t0_next;
  idea_pkg::block_t s3_next;
  logic [15:0]      t1, t0s;

  assign rdy3     = !v3 || dn_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3;

  // stage 1: key mixing of the four words
  always_comb begin
    s1_next.w0 = idea_pkg::mul_mod(up_blk.w0, subkeys[0]);
    s1_next.w1 = up_blk.w1 + subkeys[1];
    s1_next.w2 = up_blk.w2 + subkeys[2];
    s1_next.w3 = idea_pkg::mul_mod(up_blk.w3, subkeys[3]);
  end

  // stage 2: first multiply of the MA structure
  assign s2_t0_next = idea_pkg::mul_mod(s1.w0 ^ s1.w2, subkeys[4]);

  // stage 3: second multiply and output swap
  always_comb begin
    t1         = idea_pkg::mul_mod(s2_t0 + (s2.w1 ^ s2.w3), subkeys[5]);
    t0s        = s2_t0 + t1;
    s3_next.w0 = s2.w0 ^ t1;
    s3_next.w1 = s2.w2 ^ t1;
    s3_next.w2 = s2.w1 ^ t0s;
    s3_next.w3 = s2.w3 ^ t0s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) begin
      s2    <= s1;
      s2_t0 <= s2_t0_next;
    end
    if (rdy3) dn_blk <= s3_next;
  end

endmodule

`default_nettype wire

// ===== design/idea_out.sv =====
// IDEA output transform: the closing half-round, one register stage.
// Depends on idea_pkg; its register is the block's result register.
`default_nettype none

module idea_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire idea_pkg::block_t up_blk,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output idea_pkg::block_t     dn_blk,
  input  wire idea_pkg::sk4_t  subkeys
);

  logic             v;
  idea_pkg::block_t blk_next;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;

  // output key mixing; the middle words swap back
  always_comb begin
    blk_next.w0 = idea_pkg::mul_mod(up_blk.w0, subkeys[0]);
    blk_next.w1 = up_blk.w2 + subkeys[1];
    blk_next.w2 = up_blk.w1 + subkeys[2];
    blk_next.w3 = idea_pkg::mul_mod(up_blk.w3, subkeys[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) dn_blk <= blk_next;
  end

endmodule

`default_nettype wire

// ===== design/idea_block_encrypt.sv =====
// IDEA block encryption, top level: key registers, round pipeline and output transform.
// Depends on idea_pkg, idea_round and idea_out.
//
// Encrypts one 64-bit block per request under the 128-bit key in registers
// key_high (index 0) and key_low (index 1). Throughput is one block per clock
// while results are taken; the pipeline has three stages per round (each
// holding one modulo-65537 multiply on its path) plus the output transform
// stage. Every stage has its own valid bit, so bubbles close up behind a
// stalled result. Subkeys are fixed rotations of the key registers, so the
// key must only be written while no block is in flight.
`default_nettype none

module idea_block_encrypt (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             write_enable,
  input  wire logic [idea_pkg::IDX_WIDTH-1:0]   write_index,
  input  wire logic [63:0]                      write_data,
  input  wire logic                             data_valid,
  output logic                                  data_ready,
  input  wire logic [15:0]                      word0,
  input  wire logic [15:0]                      word1,
  input  wire logic [15:0]                      word2,
  input  wire logic [15:0]                      word3,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [15:0]                           out0,
  output logic [15:0]                           out1,
  output logic [15:0]                           out2,
  output logic [15:0]                           out3
);

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic [127:0] key;

  logic [idea_pkg::ROUNDS:0] stg_valid;
  logic [idea_pkg::ROUNDS:0] stg_ready;
  idea_pkg::block_t          stg_blk [idea_pkg::ROUNDS+1];
  idea_pkg::block_t          res_blk;
  idea_pkg::sk4_t            out_sk;

  assign key = {key_high, key_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= 64'd0;
      key_low  <= 64'd0;
    end else if (write_enable) begin
      unique case (write_index)
        idea_pkg::REG_KEY_HIGH: key_high <= write_data;
        idea_pkg::REG_KEY_LOW:  key_low  <= write_data;
        default: ;
      endcase
    end
  end

  assign stg_valid[0] = data_valid;
  assign data_ready   = stg_ready[0];
  assign stg_blk[0]   = '{w0: word0, w1: word1, w2: word2, w3: word3};

  for (genvar r = 0; r < idea_pkg::ROUNDS; r++) begin : g_round
    idea_pkg::sk6_t sk;
    for (genvar i = 0; i < 6; i++) begin : g_sk
      assign sk[i] = idea_pkg::subkey(key, r * 6 + i);
    end

    idea_round u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[r]),
      .up_ready (stg_ready[r]),
      .up_blk   (stg_blk[r]),
      .dn_valid (stg_valid[r+1]),
      .dn_ready (stg_ready[r+1]),
      .dn_blk   (stg_blk[r+1]),
      .subkeys  (sk)
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_out_sk
    assign out_sk[i] = idea_pkg::subkey(key, idea_pkg::ROUNDS * 6 + i);
  end

  idea_out u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[idea_pkg::ROUNDS]),
    .up_ready (stg_ready[idea_pkg::ROUNDS]),
    .up_blk   (stg_blk[idea_pkg::ROUNDS]),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_blk   (res_blk),
    .subkeys  (out_sk)
  );

  assign out0 = res_blk.w0;
  assign out1 = res_blk.w1;
  assign out2 = res_blk.w2;
  assign out3 = res_blk.w3;

endmodule

`default_nettype wire

// ===== design/idea_chk.sv =====
// Port-level checks for idea_block_encrypt, attached by bind.
// Depends on idea_pkg for the index width.
`default_nettype none

module idea_chk (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           write_enable,
  input wire logic [idea_pkg::IDX_WIDTH-1:0] write_index,
  input wire logic [63:0]                    write_data,
  input wire logic                           data_valid,
  input wire logic                           data_ready,
  input wire logic [15:0]                    word0,
  input wire logic [15:0]                    word1,
  input wire logic [15:0]                    word2,
  input wire logic [15:0]                    word3,
  input wire logic                           result_valid,
  input wire logic                           result_ready,
  input wire logic [15:0]                    out0,
  input wire logic [15:0]                    out1,
  input wire logic [15:0]                    out2,
  input wire logic [15:0]                    out3
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(out0) && $stable(out1) && $stable(out2) && $stable(out3))
    else $error("stalled result changed");

  // a waiting request holds
  a_request_hold: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_ready |=>
      data_valid && $stable(word0) && $stable(word1) && $stable(word2) && $stable(word3))
    else $error("waiting request changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // a free output end means every stage can move, so a request is taken
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (result_ready || !result_valid) |-> data_ready)
    else $error("input stalled with output free");

  // key writes carry known index and data
  a_write_known: assert property (@(posedge clk) disable iff (rst)
    write_enable |-> !$isunknown({write_index, write_data}))
    else $error("unknown key write");

endmodule

bind idea_block_encrypt idea_chk u_idea_chk (.*);

`default_nettype wire
